// ===== rtl/quaternion_trs_to_matrix_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion TRS to matrix unit
// Concurrent checks clocked on i_clk, held off while reset is low.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TRS_TO_MATRIX_UNIT_DEFINES_SVH
`define QUATERNION_TRS_TO_MATRIX_UNIT_DEFINES_SVH

// same-cycle implication
`define QTM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> cons) else $error(msg);

// next-cycle implication
`define QTM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> cons) else $error(msg);

`endif

// ===== rtl/qtm_pkg.sv =====
// ----------------------------------------------------------------------------
// qtm_pkg
// Types and fixed-point constants shared by the quaternion matrix pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qtm_pkg;

    typedef logic signed [15:0] t_q16;    // Q2.14 quaternion / Q8.8 scale
    typedef logic signed [31:0] t_word;   // Q16.16 and Q4.28 products
    typedef logic signed [33:0] t_term;   // Q6.28 rotation term
    typedef logic signed [49:0] t_full;   // Q14.36 scaled term

    localparam int N_ENTRIES  = 9;
    localparam int FRAC_SHIFT = 20;

    localparam t_term Q_ONE_Q28  = t_term'(34'sd1 <<< 28);
    localparam t_full ROUND_HALF = t_full'(50'sd1 <<< 19);
    localparam t_full Q16_MAX    = t_full'(50'sh0_7fff_ffff);
    localparam t_full Q16_MIN    = -t_full'(50'sh0_8000_0000);

    // quaternion pair products, Q4.28
    typedef struct packed {
        t_word xx;
        t_word yy;
        t_word zz;
        t_word xy;
        t_word xz;
        t_word yz;
        t_word xw;
        t_word yw;
        t_word zw;
    } t_prods;

    // fields that ride along with the rotation math
    typedef struct packed {
        t_q16  scale_x;
        t_q16  scale_y;
        t_q16  scale_z;
        t_word pos_x;
        t_word pos_y;
        t_word pos_z;
    } t_side;

    // clamp to the signed 32-bit range
    function automatic t_word sat_q16(input t_full v);
        t_word res;
        if (v > Q16_MAX) begin
            res = t_word'(32'sh7fff_ffff);
        end else if (v < Q16_MIN) begin
            res = t_word'(32'sh8000_0000);
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/quaternion_trs_to_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_trs_to_matrix_unit
// Rotation quaternion, per-axis scale and position to the top 3x4 of a
// TRS transform matrix, one transform per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the quaternion (Q2.14), scale (Q8.8) and position
//   (Q16.16) ports and raise start; the beat is taken at the clock edge
//   where start is high and busy is low. busy is held low, so a new beat
//   can be issued on every cycle.
//   Output channel: o_valid is high for exactly one cycle per input beat,
//   with the nine scaled rotation entries and the translation column on
//   the result ports. The receiver has no way to hold results off and must
//   take them in that cycle; the pipeline never stalls.
//   Throughput: one beat per cycle, set by the four register stages
//   (products, terms, scale multiply, round/clamp), each of which takes
//   a new beat every cycle; a beat passes through them in that order.
//   Reset (i_rst_n low, synchronous) clears every stage valid bit, so no
//   result comes out of a beat that was in flight; payload is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "quaternion_trs_to_matrix_unit_defines.svh"

module quaternion_trs_to_matrix_unit
    import qtm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_q16  i_quat_w,
    input  t_q16  i_quat_x,
    input  t_q16  i_quat_y,
    input  t_q16  i_quat_z,
    input  t_q16  i_scale_x,
    input  t_q16  i_scale_y,
    input  t_q16  i_scale_z,
    input  t_word i_pos_x,
    input  t_word i_pos_y,
    input  t_word i_pos_z,
    output logic  o_valid,
    output t_word o_r11,
    output t_word o_r12,
    output t_word o_r13,
    output t_word o_r21,
    output t_word o_r22,
    output t_word o_r23,
    output t_word o_r31,
    output t_word o_r32,
    output t_word o_r33,
    output t_word o_tx,
    output t_word o_ty,
    output t_word o_tz
);

    t_side  in_side;
    logic   s1_valid;
    t_prods s1_prods;
    t_side  s1_side;
    logic   s2_valid;
    t_term  s2_terms [N_ENTRIES];
    t_side  s2_side;
    t_q16   s2_scale [3];
    t_word  s4_entry [N_ENTRIES];

    // stage 3/4 valid and translation, aligned with the scale lanes
    logic   r_valid3;
    logic   r_valid4;
    t_side  r_side3;
    t_side  r_side4;

    // no back-pressure anywhere in the pipe
    assign busy = 1'b0;

    always_comb begin
        in_side.scale_x = i_scale_x;
        in_side.scale_y = i_scale_y;
        in_side.scale_z = i_scale_z;
        in_side.pos_x   = i_pos_x;
        in_side.pos_y   = i_pos_y;
        in_side.pos_z   = i_pos_z;
    end

    qtm_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_qw    (i_quat_w),
        .i_qx    (i_quat_x),
        .i_qy    (i_quat_y),
        .i_qz    (i_quat_z),
        .i_side  (in_side),
        .o_valid (s1_valid),
        .o_prods (s1_prods),
        .o_side  (s1_side)
    );

    qtm_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_prods (s1_prods),
        .i_side  (s1_side),
        .o_valid (s2_valid),
        .o_terms (s2_terms),
        .o_side  (s2_side)
    );

    // column c of the matrix takes the scale of axis c
    assign s2_scale[0] = s2_side.scale_x;
    assign s2_scale[1] = s2_side.scale_y;
    assign s2_scale[2] = s2_side.scale_z;

    for (genvar g = 0; g < N_ENTRIES; g++) begin : g_lane
        qtm_scale_lane u_lane (
            .i_clk   (i_clk),
            .i_term  (s2_terms[g]),
            .i_scale (s2_scale[g % 3]),
            .o_entry (s4_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid3 <= 1'b0;
            r_valid4 <= 1'b0;
        end else begin
            r_valid3 <= s2_valid;
            r_valid4 <= r_valid3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side3 <= s2_side;
        r_side4 <= r_side3;
    end

    assign o_valid = r_valid4;
    assign o_r11   = s4_entry[0];
    assign o_r12   = s4_entry[1];
    assign o_r13   = s4_entry[2];
    assign o_r21   = s4_entry[3];
    assign o_r22   = s4_entry[4];
    assign o_r23   = s4_entry[5];
    assign o_r31   = s4_entry[6];
    assign o_r32   = s4_entry[7];
    assign o_r33   = s4_entry[8];
    assign o_tx    = r_side4.pos_x;
    assign o_ty    = r_side4.pos_y;
    assign o_tz    = r_side4.pos_z;

    // every accepted beat comes out as a result, and nothing else does
    `QTM_ASSERT_IMP(a_beat_out, start && !busy, ##4 o_valid, "accepted beat lost")
    `QTM_ASSERT_NXT(a_no_ghost, !start, ##3 !o_valid, "result without a beat")
    // translation stays aligned with its rotation entries
    `QTM_ASSERT_IMP(a_pos_align, o_valid, o_tz == $past(i_pos_z, 4), "translation misaligned")

endmodule

// ===== rtl/qtm_prod.sv =====
// ----------------------------------------------------------------------------
// qtm_prod
// Stage 1: the nine quaternion pair products, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qtm_prod
    import qtm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_q16   i_qw,
    input  t_q16   i_qx,
    input  t_q16   i_qy,
    input  t_q16   i_qz,
    input  t_side  i_side,
    output logic   o_valid,
    output t_prods o_prods,
    output t_side  o_side
);

    logic   r_valid;
    t_prods r_prods;
    t_side  r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prods.xx <= t_word'(i_qx) * t_word'(i_qx);
        r_prods.yy <= t_word'(i_qy) * t_word'(i_qy);
        r_prods.zz <= t_word'(i_qz) * t_word'(i_qz);
        r_prods.xy <= t_word'(i_qx) * t_word'(i_qy);
        r_prods.xz <= t_word'(i_qx) * t_word'(i_qz);
        r_prods.yz <= t_word'(i_qy) * t_word'(i_qz);
        r_prods.xw <= t_word'(i_qx) * t_word'(i_qw);
        r_prods.yw <= t_word'(i_qy) * t_word'(i_qw);
        r_prods.zw <= t_word'(i_qz) * t_word'(i_qw);
        r_side     <= i_side;
    end

    assign o_valid = r_valid;
    assign o_prods = r_prods;
    assign o_side  = r_side;

endmodule

// ===== rtl/qtm_terms.sv =====
// ----------------------------------------------------------------------------
// qtm_terms
// Stage 2: rotation terms in Q6.28 from the pair products, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qtm_terms
    import qtm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_prods i_prods,
    input  t_side  i_side,
    output logic   o_valid,
    output t_term  o_terms [N_ENTRIES],
    output t_side  o_side
);

    logic  r_valid;
    t_term r_terms [N_ENTRIES];
    t_term n_terms [N_ENTRIES];
    t_side r_side;

    // doubled products
    t_term d_xx, d_yy, d_zz, d_xy, d_xz, d_yz, d_xw, d_yw, d_zw;

    always_comb begin
        d_xx = t_term'(i_prods.xx) <<< 1;
        d_yy = t_term'(i_prods.yy) <<< 1;
        d_zz = t_term'(i_prods.zz) <<< 1;
        d_xy = t_term'(i_prods.xy) <<< 1;
        d_xz = t_term'(i_prods.xz) <<< 1;
        d_yz = t_term'(i_prods.yz) <<< 1;
        d_xw = t_term'(i_prods.xw) <<< 1;
        d_yw = t_term'(i_prods.yw) <<< 1;
        d_zw = t_term'(i_prods.zw) <<< 1;

        // row-major order
        n_terms[0] = Q_ONE_Q28 - d_yy - d_zz;
        n_terms[1] = d_xy - d_zw;
        n_terms[2] = d_xz + d_yw;
        n_terms[3] = d_xy + d_zw;
        n_terms[4] = Q_ONE_Q28 - d_xx - d_zz;
        n_terms[5] = d_yz - d_xw;
        n_terms[6] = d_xz - d_yw;
        n_terms[7] = d_yz + d_xw;
        n_terms[8] = Q_ONE_Q28 - d_xx - d_yy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_terms <= n_terms;
        r_side  <= i_side;
    end

    assign o_valid = r_valid;
    assign o_terms = r_terms;
    assign o_side  = r_side;

endmodule

// ===== rtl/qtm_scale_lane.sv =====
// ----------------------------------------------------------------------------
// qtm_scale_lane
// Stages 3-4 for one entry: term times scale, then round and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qtm_scale_lane
    import qtm_pkg::*;
(
    input  logic  i_clk,
    input  t_term i_term,
    input  t_q16  i_scale,
    output t_word o_entry
);

    t_full r_prod;
    t_full n_round;
    t_word r_entry;

    // round half up, then floor shift to Q16.16
    assign n_round = (r_prod + ROUND_HALF) >>> FRAC_SHIFT;

    always_ff @(posedge i_clk) begin
        r_prod  <= t_full'(i_term) * t_full'(i_scale);
        r_entry <= sat_q16(n_round);
    end

    assign o_entry = r_entry;

endmodule
